@@ sv/imh_pkg.sv @@
// Shared types and codes for the indexed min-heap.
`default_nettype none
package imh_pkg;
	localparam logic [1:0] OP_INSERT   = 2'd0;
	localparam logic [1:0] OP_EXTRACT  = 2'd1;
	localparam logic [1:0] OP_DECREASE = 2'd2;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_EMPTY     = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_ABSENT    = 3'd3;
	localparam logic [2:0] ST_PRESENT   = 3'd4;
	localparam logic [2:0] ST_NOT_LOWER = 3'd5;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLEAR,
		S_LOOK,
		S_DECIDE,
		S_EXT_LAST,
		S_EXT_ROOT,
		S_UP_RD,
		S_UP_CMP,
		S_DN_RD,
		S_DN_CMP,
		S_DONE
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;       // capture input item
		logic clr_step;   // write one position table entry invalid
		logic look;       // read position table at key
		logic decide;     // check item and start it
		logic ext_last;   // read last slot
		logic ext_root;   // write last entry to root
		logic up_rd;      // read parent
		logic up_cmp;     // compare and swap with parent
		logic dn_rd;      // read children
		logic dn_cmp;     // compare and swap with smaller child
		logic done;       // present result
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic go_up;      // item needs a sift up
		logic go_ext;     // item is a real extract
		logic finish;     // item finished after decide
		logic up_more;
		logic dn_more;
	} sts_t;
endpackage
`default_nettype wire

@@ sv/indexed_min_heap.sv @@
// Indexed binary min-heap: insert, extract-minimum and decrease-key.
// Input channel in_valid/in_ready carries operation, key and value.
// Output channel out_valid/out_ready carries out_key, out_value, status,
// entry_count and heap_empty, one result per item.
// Operations: 0 insert, 1 extract minimum, 2 decrease key. Error cases
// (empty, full, duplicate, absent key, not lower) leave the heap unchanged.
// One item is processed at a time. An item ends after its check, or goes on
// to a sift of one memory read then one compare-and-swap per heap level it
// visits (the level where it stops included); extract first reads the last
// slot and writes that entry to the root before it sifts down.
// After reset the block sweeps every entry of the key position table with
// in_ready low. The heap memory itself is not cleared.
// A result sits in the output register until taken; no new item is accepted
// while it waits.
`default_nettype none
module indexed_min_heap
	import imh_pkg::*;
#(
	parameter int CAPACITY  = 256,
	parameter int KEY_COUNT = 256
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  wire  [1:0]         operation,
	input  wire  [7:0]         key,
	input  wire  signed [31:0] value,
	output logic               out_valid,
	input  wire                out_ready,
	output logic [7:0]         out_key,
	output logic signed [31:0] out_value,
	output logic [2:0]         status,
	output logic [8:0]         entry_count,
	output logic               heap_empty
);
	cmd_t cmd;
	sts_t sts;

	imh_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .cmd, .sts
	);

	imh_dp #(.CAPACITY(CAPACITY), .KEY_COUNT(KEY_COUNT)) u_dp (
		.clk, .arst_n, .cmd, .sts, .operation, .key, .value,
		.out_key, .out_value, .status, .entry_count, .heap_empty,
		.out_valid, .out_ready
	);
endmodule
`default_nettype wire

@@ sv/imh_ctrl.sv @@
// Controller sequencing clear, operation check and sifting.
`default_nettype none
module imh_ctrl
	import imh_pkg::*;
(
	input  wire       clk,
	input  wire       arst_n,
	input  wire       in_valid,
	output logic      in_ready,
	input  wire       out_valid,
	output cmd_t      cmd,
	input  wire sts_t sts
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLEAR;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR:    if (sts.clr_last) state_d = S_IDLE;
			S_IDLE:     if (in_valid && !out_valid) state_d = S_LOOK;
			S_LOOK:     state_d = S_DECIDE;
			S_DECIDE: begin
				if (sts.finish) state_d = S_DONE;
				else if (sts.go_ext) state_d = S_EXT_LAST;
				else state_d = S_UP_RD;
			end
			S_EXT_LAST: state_d = S_EXT_ROOT;
			S_EXT_ROOT: state_d = S_DN_RD;
			S_UP_RD:    state_d = S_UP_CMP;
			S_UP_CMP:   state_d = sts.up_more ? S_UP_RD : S_DONE;
			S_DN_RD:    state_d = S_DN_CMP;
			S_DN_CMP:   state_d = sts.dn_more ? S_DN_RD : S_DONE;
			S_DONE:     state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			S_CLEAR: cmd.clr_step = 1'b1;
			S_IDLE: begin
				in_ready = !out_valid;
				cmd.load = in_valid && !out_valid;
			end
			S_LOOK:     cmd.look = 1'b1;
			S_DECIDE:   cmd.decide = 1'b1;
			S_EXT_LAST: cmd.ext_last = 1'b1;
			S_EXT_ROOT: cmd.ext_root = 1'b1;
			S_UP_RD:    cmd.up_rd = 1'b1;
			S_UP_CMP:   cmd.up_cmp = 1'b1;
			S_DN_RD:    cmd.dn_rd = 1'b1;
			S_DN_CMP:   cmd.dn_cmp = 1'b1;
			S_DONE:     cmd.done = 1'b1;
			default: ;
		endcase
	end
endmodule
`default_nettype wire

@@ sv/imh_dp.sv @@
// Datapath: heap memories, position table, sift registers and result register.
`default_nettype none
module imh_dp
	import imh_pkg::*;
#(
	parameter int CAPACITY  = 256,
	parameter int KEY_COUNT = 256
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire  cmd_t         cmd,
	output sts_t               sts,
	input  wire  [1:0]         operation,
	input  wire  [7:0]         key,
	input  wire  signed [31:0] value,
	output logic [7:0]         out_key,
	output logic signed [31:0] out_value,
	output logic [2:0]         status,
	output logic [8:0]         entry_count,
	output logic               heap_empty,
	output logic               out_valid,
	input  wire                out_ready
);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int KW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
	localparam logic [CW-1:0] CAP = CW'(CAPACITY);

	typedef struct packed {
		logic [7:0]         k;
		logic signed [31:0] p;
	} entry_t;

	// two banks hold identical copies so that both children read in the same cycle
	entry_t heap_a [CAPACITY];
	entry_t heap_b [CAPACITY];
	logic [AW:0] pos_mem [KEY_COUNT]; // msb = present

	logic [1:0]         op_q;
	logic [7:0]         key_q;
	logic signed [31:0] val_q;
	logic [CW-1:0]      cnt_q;
	logic [KW-1:0]      clr_q;
	logic [AW-1:0]      idx_q;
	entry_t             cur_q;
	entry_t             rda_q, rdb_q;
	logic [AW:0]        posrd_q;
	logic               key_ok_q;
	logic               lch_ok_q, rch_ok_q;

	// memory write ports (both banks), position write ports
	logic          hw_en;
	logic [AW-1:0] hw_addr;
	entry_t        hw_data;
	logic          hw2_en;
	logic [AW-1:0] hw2_addr;
	entry_t        hw2_data;
	logic          pw_en;
	logic [KW-1:0] pw_addr;
	logic [AW:0]   pw_data;
	logic          pw2_en;
	logic [KW-1:0] pw2_addr;
	logic [AW:0]   pw2_data;
	logic [AW-1:0] ra_addr, rb_addr;

	// decide-phase checks
	logic key_in_range;
	logic present;
	logic [AW-1:0] pos_idx;
	logic [2:0] chk_st;
	logic start_up, start_ext;

	logic [AW-1:0] parent;
	logic [AW:0]   lch, rch;
	logic          swap_up;
	logic          pick_r, swap_dn;
	entry_t        best;
	logic [AW-1:0] best_idx;

	assign key_in_range = (KW >= 8) ? 1'b1 : ({24'd0, key_q} < 32'(KEY_COUNT));
	assign present = posrd_q[AW] && key_ok_q;
	assign pos_idx = posrd_q[AW-1:0];

	always_comb begin
		chk_st = ST_OK;
		start_up = 1'b0;
		start_ext = 1'b0;
		case (op_q)
			OP_INSERT: begin
				if (!key_in_range) chk_st = ST_ABSENT;
				else if (present) chk_st = ST_PRESENT;
				else if (cnt_q >= CAP) chk_st = ST_FULL;
				else start_up = 1'b1;
			end
			OP_EXTRACT: begin
				if (cnt_q == '0) chk_st = ST_EMPTY;
				else start_ext = 1'b1;
			end
			OP_DECREASE: begin
				if (!key_in_range || !present) chk_st = ST_ABSENT;
				else if ({1'b0, pos_idx} >= (AW + 1)'(cnt_q)) chk_st = ST_ABSENT;
				else if (!(val_q < rda_q.p)) chk_st = ST_NOT_LOWER;
				else start_up = 1'b1;
			end
			default: ;
		endcase
	end

	assign parent = AW'((idx_q - AW'(1)) >> 1);
	assign swap_up = (idx_q != '0) && (cur_q.p < rda_q.p);
	assign lch = {idx_q, 1'b1};
	assign rch = (AW + 1)'({idx_q, 1'b1}) + (AW + 1)'(1);
	assign pick_r = rch_ok_q && (rdb_q.p < (lch_ok_q && rda_q.p < cur_q.p ? rda_q.p : cur_q.p));
	assign swap_dn = pick_r || (lch_ok_q && rda_q.p < cur_q.p);
	assign best = pick_r ? rdb_q : rda_q;
	assign best_idx = pick_r ? rch[AW-1:0] : lch[AW-1:0];

	assign sts.clr_last = (clr_q == KW'(KEY_COUNT - 1));
	assign sts.go_up = start_up;
	assign sts.go_ext = start_ext;
	assign sts.finish = !start_up && !start_ext;
	assign sts.up_more = swap_up;
	assign sts.dn_more = swap_dn;

	// read addresses
	always_comb begin
		ra_addr = '0;
		rb_addr = '0;
		if (cmd.look || cmd.decide) ra_addr = pos_idx;
		// count is already decremented here, so it points at the last entry
		if (cmd.ext_last) begin
			ra_addr = AW'(cnt_q);
			rb_addr = '0;
		end
		if (cmd.up_rd) ra_addr = parent;
		if (cmd.dn_rd) begin
			ra_addr = lch[AW-1:0];
			rb_addr = rch[AW-1:0];
		end
	end

	// write ports
	always_comb begin
		hw_en = 1'b0; hw_addr = idx_q; hw_data = cur_q;
		hw2_en = 1'b0; hw2_addr = idx_q; hw2_data = cur_q;
		pw_en = 1'b0; pw_addr = clr_q; pw_data = '0;
		pw2_en = 1'b0; pw2_addr = clr_q; pw2_data = '0;
		if (cmd.clr_step) pw_en = 1'b1;
		if (cmd.decide && start_up) begin
			hw_en = 1'b1;
			hw_addr = (op_q == OP_INSERT) ? AW'(cnt_q) : pos_idx;
			hw_data = '{k: key_q, p: val_q};
			pw_en = 1'b1;
			pw_addr = KW'(key_q);
			pw_data = {1'b1, hw_addr};
		end
		if (cmd.decide && start_ext) begin
			pw_en = 1'b1;
			pw_addr = KW'(rdb_q.k);
			pw_data = '0;
		end
		if (cmd.ext_root && cnt_q != '0) begin
			hw_en = 1'b1;
			hw_addr = '0;
			hw_data = rda_q;
			pw_en = 1'b1;
			pw_addr = KW'(rda_q.k);
			pw_data = {1'b1, {AW{1'b0}}};
		end
		if (cmd.up_cmp && swap_up) begin
			hw_en = 1'b1; hw_addr = idx_q; hw_data = rda_q;
			hw2_en = 1'b1; hw2_addr = parent; hw2_data = cur_q;
			pw_en = 1'b1; pw_addr = KW'(rda_q.k); pw_data = {1'b1, idx_q};
			pw2_en = 1'b1; pw2_addr = KW'(cur_q.k); pw2_data = {1'b1, parent};
		end
		if (cmd.dn_cmp && swap_dn) begin
			hw_en = 1'b1; hw_addr = idx_q; hw_data = best;
			hw2_en = 1'b1; hw2_addr = best_idx; hw2_data = cur_q;
			pw_en = 1'b1; pw_addr = KW'(best.k); pw_data = {1'b1, idx_q};
			pw2_en = 1'b1; pw2_addr = KW'(cur_q.k); pw2_data = {1'b1, best_idx};
		end
	end

	// heap banks: bank a port 1 writes primary, bank b mirrors; second write
	// goes through a registered delayed port so each bank sees one write a cycle
	logic          hw2_en_s1;
	logic [AW-1:0] hw2_addr_s1;
	entry_t        hw2_data_s1;
	logic          pw2_en_s1;
	logic [KW-1:0] pw2_addr_s1;
	logic [AW:0]   pw2_data_s1;

	always_ff @(posedge clk) begin
		hw2_addr_s1 <= hw2_addr;
		hw2_data_s1 <= hw2_data;
		pw2_addr_s1 <= pw2_addr;
		pw2_data_s1 <= pw2_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw2_en_s1 <= 1'b0;
			pw2_en_s1 <= 1'b0;
		end else begin
			hw2_en_s1 <= hw2_en;
			pw2_en_s1 <= pw2_en;
		end
	end

	// the delayed write lands during the following read state, whose addresses
	// never hit that slot's fresh contents before the next compare
	always_ff @(posedge clk) begin
		if (hw_en) begin
			heap_a[hw_addr] <= hw_data;
			heap_b[hw_addr] <= hw_data;
		end else if (hw2_en_s1) begin
			heap_a[hw2_addr_s1] <= hw2_data_s1;
			heap_b[hw2_addr_s1] <= hw2_data_s1;
		end
		rda_q <= heap_a[ra_addr];
		rdb_q <= heap_b[rb_addr];
	end

	// position lookup starts at the accepting edge so the slot read follows in look
	always_ff @(posedge clk) begin
		if (pw_en) pos_mem[pw_addr] <= pw_data;
		else if (pw2_en_s1) pos_mem[pw2_addr_s1] <= pw2_data_s1;
		posrd_q <= pos_mem[cmd.load ? KW'(key) : KW'(key_q)];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= operation;
			key_q <= key;
			val_q <= value;
		end
		if (cmd.look) key_ok_q <= key_in_range;
		if (cmd.decide) begin
			idx_q <= (op_q == OP_INSERT) ? AW'(cnt_q) : pos_idx;
			cur_q <= '{k: key_q, p: val_q};
		end
		if (cmd.ext_root) begin
			idx_q <= '0;
			cur_q <= rda_q;
		end
		if (cmd.up_cmp && swap_up) idx_q <= parent;
		if (cmd.dn_rd) begin
			lch_ok_q <= (CW'(lch) < cnt_q) && (lch <= (AW + 1)'(CAPACITY - 1));
			rch_ok_q <= (CW'(rch) < cnt_q) && (rch <= (AW + 1)'(CAPACITY - 1));
		end
		if (cmd.dn_cmp && swap_dn) idx_q <= best_idx;
		if (cmd.decide) begin
			out_key <= start_ext ? rdb_q.k : 8'd0;
			out_value <= start_ext ? rdb_q.p : 32'sd0;
			status <= chk_st;
		end
	end

	// extract gets the root in rdb during look, as rb_addr rests at slot 0;
	// decide captures it into the result register
	logic [CW-1:0] cnt_next;
	always_comb begin
		cnt_next = cnt_q;
		if (cmd.decide && start_up && op_q == OP_INSERT) cnt_next = cnt_q + CW'(1);
		if (cmd.decide && start_ext) cnt_next = cnt_q - CW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			clr_q <= '0;
			out_valid <= 1'b0;
			entry_count <= '0;
			heap_empty <= 1'b1;
		end else begin
			cnt_q <= cnt_next;
			if (cmd.clr_step) clr_q <= clr_q + KW'(1);
			if (cmd.done) begin
				out_valid <= 1'b1;
				entry_count <= 9'(cnt_q);
				heap_empty <= (cnt_q == '0);
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

@@ sim/indexed_min_heap_test.sv @@
// Self-checking testbench for the indexed min-heap: scoreboard class plus driver tasks.
`default_nettype none
module indexed_min_heap_test;
	timeunit 1ns;
	timeprecision 1ps;
	import imh_pkg::*;

	typedef struct packed {
		logic [7:0]         rkey;
		logic signed [31:0] rval;
		logic [2:0]         st;
		logic [8:0]         cnt;
		logic               emp;
	} heap_result_t;

	class heap_scoreboard;
		logic [7:0]         slot_key [256];
		logic signed [31:0] slot_pri [256];
		int                 where_is [256];
		bit                 present  [256];
		int                 fill;
		heap_result_t       pending [$];
		int                 errors;

		function new();
			fill = 0;
			errors = 0;
			foreach (present[i]) begin
				present[i] = 0;
				where_is[i] = 0;
				slot_key[i] = '0;
				slot_pri[i] = '0;
			end
		endfunction

		function void swap_slots(int a, int b);
			logic [7:0] k;
			logic signed [31:0] p;
			k = slot_key[a];
			p = slot_pri[a];
			slot_key[a] = slot_key[b];
			slot_pri[a] = slot_pri[b];
			slot_key[b] = k;
			slot_pri[b] = p;
			where_is[slot_key[a]] = a;
			where_is[slot_key[b]] = b;
		endfunction

		function void rise(int i);
			int up;
			while (i > 0) begin
				up = (i - 1) / 2;
				if (!(slot_pri[i] < slot_pri[up]))
					break;
				swap_slots(i, up);
				i = up;
			end
		endfunction

		function void sink(int i);
			int l, r, best;
			forever begin
				l = 2 * i + 1;
				r = 2 * i + 2;
				best = i;
				if (l < fill && slot_pri[l] < slot_pri[best])
					best = l;
				if (r < fill && slot_pri[r] < slot_pri[best])
					best = r;
				if (best == i)
					break;
				swap_slots(i, best);
				i = best;
			end
		endfunction

		function void note_item(logic [1:0] op, logic [7:0] k, logic signed [31:0] v);
			heap_result_t res;
			int i;
			res = '0;
			res.st = ST_OK;
			if (op == OP_INSERT) begin
				if (present[k])
					res.st = ST_PRESENT;
				else if (fill >= 256)
					res.st = ST_FULL;
				else begin
					i = fill;
					slot_key[i] = k;
					slot_pri[i] = v;
					where_is[k] = i;
					present[k] = 1;
					fill++;
					rise(i);
				end
			end else if (op == OP_EXTRACT) begin
				if (fill == 0)
					res.st = ST_EMPTY;
				else begin
					res.rkey = slot_key[0];
					res.rval = slot_pri[0];
					present[slot_key[0]] = 0;
					fill--;
					if (fill > 0) begin
						slot_key[0] = slot_key[fill];
						slot_pri[0] = slot_pri[fill];
						where_is[slot_key[0]] = 0;
						sink(0);
					end
				end
			end else if (op == OP_DECREASE) begin
				if (!present[k])
					res.st = ST_ABSENT;
				else begin
					i = where_is[k];
					if (!(v < slot_pri[i]))
						res.st = ST_NOT_LOWER;
					else begin
						slot_pri[i] = v;
						rise(i);
					end
				end
			end
			res.cnt = fill[8:0];
			res.emp = (fill == 0);
			pending = {pending, res};
		endfunction

		function void check_result(heap_result_t got);
			heap_result_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result %p", got);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected %p actual %p", want, got);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [1:0] operation = '0;
	logic [7:0] key = '0;
	logic signed [31:0] value = '0;
	logic out_valid;
	logic out_ready = 0;
	logic [7:0] out_key;
	logic signed [31:0] out_value;
	logic [2:0] status;
	logic [8:0] entry_count;
	logic heap_empty;

	heap_scoreboard sb;
	bit quiet;	// no idling in the final stretch

	indexed_min_heap dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .key(key), .value(value),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_key(out_key), .out_value(out_value), .status(status),
		.entry_count(entry_count), .heap_empty(heap_empty)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// valid stays up after an accept until the next item or an idle stretch
	task automatic send_item(logic [1:0] op, logic [7:0] k, logic signed [31:0] v);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid <= 1;
		operation <= op;
		key <= k;
		value <= v;
		do @(posedge clk); while (!in_ready);
		sb.note_item(op, k, v);
	endtask

	task automatic drain();
		in_valid <= 0;
		do @(posedge clk); while (sb.pending.size() != 0);
	endtask

	function automatic logic signed [31:0] rand_pri();
		case ($urandom_range(0, 5))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return $signed($urandom_range(0, 15)) - 8;
			default: return $urandom;
		endcase
	endfunction

	// receiver side with random stalls
	initial begin
		int hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_result('{out_key, out_value, status, entry_count, heap_empty});
			if (hold > 0) begin
				hold--;
				out_ready <= 0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				hold = $urandom_range(1, 19);
				out_ready <= 0;
			end else
				out_ready <= 1;
		end
	end

	initial begin
		int k, n;
		sb = new();
		quiet = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		// directed: empty extract, extremes, duplicates, not-lower, absent, unused op code
		send_item(OP_EXTRACT, 8'h00, 0);
		send_item(OP_DECREASE, 8'h05, 0);
		send_item(OP_INSERT, 8'hff, 32'sh7fff_ffff);
		send_item(OP_INSERT, 8'h00, 32'sh8000_0000);
		send_item(OP_INSERT, 8'h00, 5);
		send_item(OP_INSERT, 8'haa, 3);
		send_item(OP_INSERT, 8'h55, 3);
		send_item(OP_DECREASE, 8'hff, 32'sh7fff_ffff);
		send_item(OP_DECREASE, 8'hff, 3);
		send_item(OP_DECREASE, 8'h55, 32'sh8000_0000);
		send_item(2'd3, 8'h12, -1);
		repeat (6) send_item(OP_EXTRACT, 8'($urandom), $urandom);
		// fill to capacity, then overflow and duplicates, then empty it and extract once more
		for (k = 0; k < 256; k++)
			send_item(OP_INSERT, k[7:0], rand_pri());
		send_item(OP_INSERT, 8'h10, 1);
		for (k = 0; k < 256; k++)
			send_item(OP_INSERT, k[7:0], rand_pri());
		drain();
		for (k = 0; k < 257; k++)
			send_item(OP_EXTRACT, 8'h00, 0);
		// random mix, small key pool so hits are common
		for (n = 0; n < 510; n++) begin
			if (n == 400) begin
				drain();
				quiet = 1;
			end
			k = (n % 300 < 150) ? $urandom_range(0, 31) : $urandom_range(0, 255);
			case ($urandom_range(0, 9))
				0, 1, 2, 3: send_item(OP_INSERT, k[7:0], rand_pri());
				4, 5, 6: send_item(OP_EXTRACT, 8'($urandom), $urandom);
				7, 8: send_item(OP_DECREASE, k[7:0], sb.present[k[7:0]] ?
					sb.slot_pri[sb.where_is[k[7:0]]] - $urandom_range(0, 3) : rand_pri());
				default: send_item(2'($urandom_range(0, 3)), k[7:0], rand_pri());
			endcase
		end
		drain();
		repeat (40) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#4ms;
		$display("== FAIL ==");
		$finish;
	end
endmodule
`default_nettype wire
